// ===== hw/rtl/ifsd_pkg.sv =====
// Shared types and constants for the IMU frame sync decoder.
package ifsd_pkg;

    localparam int unsigned FRAME_LEN = 11;
    // The eleventh byte is compared on arrival, so only ten bytes are held.
    localparam int unsigned WIN_LEN   = FRAME_LEN - 1;
    localparam int unsigned WIN_IDX_W = $clog2(WIN_LEN);
    localparam int unsigned FILL_W    = 4;

    localparam logic [7:0] SYNC_BYTE  = 8'h55;
    localparam logic [7:0] TYPE_ACCEL = 8'h51;
    localparam logic [7:0] TYPE_GYRO  = 8'h52;
    localparam logic [7:0] TYPE_ANGLE = 8'h53;

    typedef enum logic [1:0] {
        KIND_ACCEL = 2'd0,
        KIND_GYRO  = 2'd1,
        KIND_ANGLE = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
        logic signed [15:0] temp_raw;
    } t_result;

endpackage

// ===== hw/rtl/ifsd_front.sv =====
// Front end: byte window, sync and checksum check, frame type decode.
module ifsd_front
    import ifsd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_rx_byte,
    output logic       o_push,
    output t_result    o_push_data
);

    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    logic [7:0]        r_win [WIN_LEN];
    logic [7:0]        n_win [WIN_LEN];
    logic [7:0]        w_sum;
    logic [7:0]        w_pair [WIN_LEN/2];
    logic              w_full;
    logic              w_frame_ok;
    logic              w_known;
    t_kind             w_kind;

    // Sum the ten held bytes modulo 256 as a shallow tree
    always_comb begin
        for (int i = 0; i < WIN_LEN / 2; i++) begin
            w_pair[i] = r_win[2*i] + r_win[2*i+1];
        end
        w_sum = '0;
        for (int i = 0; i < WIN_LEN / 2; i++) begin
            w_sum = w_sum + w_pair[i];
        end
    end

    // Check the frame when the incoming byte completes the window
    assign w_full     = (r_fill >= FILL_W'(WIN_LEN));
    assign w_frame_ok = w_full && (r_win[0] == SYNC_BYTE) && (w_sum == i_rx_byte);

    // Decode the frame type byte
    always_comb begin
        w_known = 1'b1;
        w_kind  = KIND_ACCEL;
        unique case (r_win[1])
            TYPE_ACCEL: w_kind = KIND_ACCEL;
            TYPE_GYRO:  w_kind = KIND_GYRO;
            TYPE_ANGLE: w_kind = KIND_ANGLE;
            default:    w_known = 1'b0;
        endcase
    end

    // Hand a decoded frame to the queue
    assign o_push               = i_accept && w_frame_ok && w_known;
    assign o_push_data.kind     = w_kind;
    assign o_push_data.axis_x   = {r_win[3], r_win[2]};
    assign o_push_data.axis_y   = {r_win[5], r_win[4]};
    assign o_push_data.axis_z   = {r_win[7], r_win[6]};
    assign o_push_data.temp_raw = {r_win[9], r_win[8]};

    // Append, clear on a good frame, or slide by one byte on a bad one
    always_comb begin
        n_fill = r_fill;
        n_win  = r_win;
        if (i_accept) begin
            if (!w_full) begin
                for (int i = 0; i < WIN_LEN; i++) begin
                    if (r_fill == FILL_W'(i)) begin
                        n_win[i] = i_rx_byte;
                    end
                end
                n_fill = r_fill + 1'b1;
            end else if (w_frame_ok) begin
                n_fill = '0;
            end else begin
                for (int i = 0; i < WIN_LEN - 1; i++) begin
                    n_win[i] = r_win[i+1];
                end
                n_win[WIN_LEN-1] = i_rx_byte;
                n_fill = FILL_W'(WIN_LEN);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(WIN_LEN))
        else $error("window fill count beyond ten bytes");

    a_clear_after_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> (r_fill == '0))
        else $error("window not cleared after an accepted frame");
`endif

endmodule

// ===== hw/rtl/ifsd_queue.sv =====
// Short result queue between the front end and the output stage.
module ifsd_queue
    import ifsd_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_push_data,
    output logic    o_full,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_pop
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_result          r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_wr;
    logic             w_rd;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;

    // Store a pushed entry
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("result pushed into a full queue");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr && !w_rd) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not advance on push");
`endif

endmodule

// ===== hw/rtl/ifsd_back.sv =====
// Output stage: registers one decoded result toward the consumer.
module ifsd_back
    import ifsd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    input  t_result i_q_data,
    output logic    o_q_pop,
    input  logic    i_stall,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    // Load when the register is empty or its transaction completes
    assign o_q_pop = i_q_valid && (!r_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_res <= i_q_data;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ===== hw/rtl/imu_frame_sync_decoder.sv =====
// Top level: 11-byte sensor frame synchronizer and decoder.
// Throughput: one byte per cycle; input stalls only while the result queue is full.
// Path: the final byte of a frame is checked and written into the queue as it is accepted,
//   then the output register loads it from the queue head and raises o_valid.
// Reset: synchronous active-low i_rst_n empties the window, queue and output register.
module imu_frame_sync_decoder
    import ifsd_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_rx_byte,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_kind,
    output logic signed [15:0] o_axis_x,
    output logic signed [15:0] o_axis_y,
    output logic signed [15:0] o_axis_z,
    output logic signed [15:0] o_temp_raw
);

    logic    w_accept;
    logic    w_push;
    t_result w_push_data;
    logic    w_q_full;
    logic    w_q_valid;
    t_result w_q_data;
    logic    w_q_pop;
    t_result w_res;

    assign o_stall  = w_q_full;
    assign w_accept = i_valid && !w_q_full;

    ifsd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_rx_byte   (i_rx_byte),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    ifsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_full      (w_q_full),
        .o_valid     (w_q_valid),
        .o_data      (w_q_data),
        .i_pop       (w_q_pop)
    );

    ifsd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_data  (w_q_data),
        .o_q_pop   (w_q_pop),
        .i_stall   (i_stall),
        .o_valid   (o_valid),
        .o_res     (w_res)
    );

    assign o_kind     = w_res.kind;
    assign o_axis_x   = w_res.axis_x;
    assign o_axis_y   = w_res.axis_y;
    assign o_axis_z   = w_res.axis_z;
    assign o_temp_raw = w_res.temp_raw;

endmodule

// ===== verif/ifsd_frame_scoreboard.sv =====
`timescale 1ns / 100ps
// Scoreboard for the IMU frame sync decoder: byte-level frame predictor and result checker.
package ifsd_scoreboard_pkg;

    import ifsd_pkg::*;

    class frame_scoreboard;

        logic [7:0]  window [0:FRAME_LEN-1];
        int unsigned fill_count;
        t_result     expected_frames [$];
        int unsigned error_count;

        function new();
            foreach (window[i]) window[i] = 8'h00;
            fill_count  = 0;
            error_count = 0;
        endfunction

        // Advance the frame window by one accepted byte and queue any decoded result.
        function void note_byte(logic [7:0] value);
            logic [7:0] sum;
            t_result    frame_result;
            bit         known_type;

            window[fill_count] = value;
            fill_count++;
            if (fill_count < FRAME_LEN) return;

            sum = 8'h00;
            for (int i = 0; i < FRAME_LEN - 1; i++) sum += window[i];

            // Drop the oldest byte on a bad sync byte or checksum
            if (window[0] != SYNC_BYTE || sum != window[FRAME_LEN-1]) begin
                for (int i = 0; i < FRAME_LEN - 1; i++) window[i] = window[i+1];
                window[FRAME_LEN-1] = 8'h00;
                fill_count = FRAME_LEN - 1;
                return;
            end

            known_type = 1'b1;
            case (window[1])
                TYPE_ACCEL: frame_result.kind = KIND_ACCEL;
                TYPE_GYRO:  frame_result.kind = KIND_GYRO;
                TYPE_ANGLE: frame_result.kind = KIND_ANGLE;
                default:    known_type = 1'b0;
            endcase
            if (known_type) begin
                frame_result.axis_x   = {window[3], window[2]};
                frame_result.axis_y   = {window[5], window[4]};
                frame_result.axis_z   = {window[7], window[6]};
                frame_result.temp_raw = {window[9], window[8]};
                expected_frames.push_back(frame_result);
            end

            // Consume the whole frame
            foreach (window[i]) window[i] = 8'h00;
            fill_count = 0;
        endfunction

        // Compare one output transaction against the oldest decoded frame.
        function void check_result(t_result actual);
            t_result exp_frame;

            if (expected_frames.size() == 0) begin
                $error("unexpected result: kind %0d x %0d y %0d z %0d temp %0d",
                       actual.kind, actual.axis_x, actual.axis_y, actual.axis_z,
                       actual.temp_raw);
                error_count++;
                return;
            end
            exp_frame = expected_frames.pop_front();
            if (actual.kind !== exp_frame.kind) begin
                $error("kind: expected %0d, actual %0d", exp_frame.kind, actual.kind);
                error_count++;
            end
            if (actual.axis_x !== exp_frame.axis_x) begin
                $error("axis_x: expected %0d, actual %0d", exp_frame.axis_x, actual.axis_x);
                error_count++;
            end
            if (actual.axis_y !== exp_frame.axis_y) begin
                $error("axis_y: expected %0d, actual %0d", exp_frame.axis_y, actual.axis_y);
                error_count++;
            end
            if (actual.axis_z !== exp_frame.axis_z) begin
                $error("axis_z: expected %0d, actual %0d", exp_frame.axis_z, actual.axis_z);
                error_count++;
            end
            if (actual.temp_raw !== exp_frame.temp_raw) begin
                $error("temp_raw: expected %0d, actual %0d",
                       exp_frame.temp_raw, actual.temp_raw);
                error_count++;
            end
        endfunction

    endclass

endpackage

// ===== verif/imu_frame_sync_decoder_test.sv =====
`timescale 1ns / 100ps
// Testbench top for the IMU frame sync decoder: directed and random byte streams.
module imu_frame_sync_decoder_test;

    import ifsd_pkg::*;
    import ifsd_scoreboard_pkg::*;

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               i_valid    = 1'b0;
    logic [7:0]         i_rx_byte  = 8'h00;
    logic               i_stall    = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic [1:0]         o_kind;
    logic signed [15:0] o_axis_x;
    logic signed [15:0] o_axis_y;
    logic signed [15:0] o_axis_z;
    logic signed [15:0] o_temp_raw;

    frame_scoreboard sb = new();
    int unsigned     send_idle_pct  = 0;
    int unsigned     recv_stall_pct = 0;
    int unsigned     bytes_sent     = 0;

    imu_frame_sync_decoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_rx_byte  (i_rx_byte),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_kind     (o_kind),
        .o_axis_x   (o_axis_x),
        .o_axis_y   (o_axis_y),
        .o_axis_z   (o_axis_z),
        .o_temp_raw (o_temp_raw)
    );

    // Clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Hard limit on run time
    initial begin
        #20_000_000;
        $display("imu_frame_sync_decoder: mismatch");
        $finish;
    end

    // Drain results with random stalls and check each transaction
    initial begin
        t_result actual;

        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                actual.kind     = t_kind'(o_kind);
                actual.axis_x   = o_axis_x;
                actual.axis_y   = o_axis_y;
                actual.axis_z   = o_axis_z;
                actual.temp_raw = o_temp_raw;
                sb.check_result(actual);
            end
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Present one byte, idling at random first, and hold it until accepted.
    task automatic send_byte(input logic [7:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= value;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_byte(value);
        bytes_sent++;
    endtask

    // Build an 11-byte frame with its sum checksum, optionally corrupted.
    task automatic send_frame(input logic [7:0] frame_type, input logic [15:0] x,
                              input logic [15:0] y, input logic [15:0] z,
                              input logic [15:0] temp, input bit corrupt);
        logic [7:0] frame [0:FRAME_LEN-1];
        logic [7:0] sum;

        frame[0] = SYNC_BYTE;
        frame[1] = frame_type;
        frame[2] = x[7:0];
        frame[3] = x[15:8];
        frame[4] = y[7:0];
        frame[5] = y[15:8];
        frame[6] = z[7:0];
        frame[7] = z[15:8];
        frame[8] = temp[7:0];
        frame[9] = temp[15:8];
        sum = 8'h00;
        for (int i = 0; i < FRAME_LEN - 1; i++) sum += frame[i];
        frame[FRAME_LEN-1] = corrupt ? (sum ^ 8'($urandom_range(255, 1))) : sum;
        for (int i = 0; i < FRAME_LEN; i++) send_byte(frame[i]);
    endtask

    // Mostly valid frames with random content, mixed with noise and bad checksums.
    task automatic send_random(input int unsigned count);
        int unsigned target;
        int unsigned pick;
        logic [7:0]  frame_type;

        target = bytes_sent + count;
        while (bytes_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                repeat ($urandom_range(4, 1)) begin
                    send_byte(($urandom_range(3) == 0) ? SYNC_BYTE : 8'($urandom));
                end
            end else begin
                case ($urandom_range(19))
                    0, 1, 2, 3, 4, 5:        frame_type = TYPE_ACCEL;
                    6, 7, 8, 9, 10, 11:      frame_type = TYPE_GYRO;
                    12, 13, 14, 15, 16, 17:  frame_type = TYPE_ANGLE;
                    default:                 frame_type = 8'($urandom);
                endcase
                send_frame(frame_type, 16'($urandom), 16'($urandom), 16'($urandom),
                           16'($urandom), pick < 14);
            end
        end
    endtask

    // Main sequence
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct  = 22;
        recv_stall_pct = 86;

        // Partial window, then resync onto a frame with extreme values
        send_byte(8'hFF);
        send_byte(8'h00);
        send_frame(TYPE_ACCEL, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 1'b0);
        send_frame(TYPE_GYRO, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 1'b0);
        send_frame(TYPE_ANGLE, 16'h1234, 16'hA5A5, 16'h5A5A, 16'h0001, 1'b0);
        // Valid frame of unknown type is consumed silently
        send_frame(8'h54, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 1'b0);
        // Bad checksum forces a byte-by-byte slide
        send_frame(TYPE_ACCEL, 16'h0102, 16'h0304, 16'h0506, 16'h0708, 1'b1);
        send_random(300);

        send_idle_pct  = 86;
        recv_stall_pct = 22;
        send_random(300);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_random(300);

        i_valid <= 1'b0;
        while (sb.expected_frames.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (sb.error_count == 0 && sb.expected_frames.size() == 0) begin
            $display("imu_frame_sync_decoder: match");
        end else begin
            $display("imu_frame_sync_decoder: mismatch");
        end
        $finish;
    end

endmodule
